// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the maze backtracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define GMB_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GMB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GMB_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg)
`define GMB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

// File: rtl/gmb_pkg.sv
// Shared constants, codes and controller/datapath interface types of the maze backtracker.
`default_nettype none

package gmb_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 32;
  localparam int NUM_CELLS = MAX_ROWS * MAX_COLS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;
  localparam int CELL_W = $clog2(NUM_CELLS);
  localparam int LVL_W  = CELL_W + 1;
  localparam int CFG_W  = 6;
  localparam int WALL_W = 4;
  localparam int DIR_W  = 2;

  // Directions, also the bit position of the matching wall.
  localparam logic [DIR_W-1:0] DIR_TOP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BOTTOM = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd3;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd20;

  typedef struct packed {
    logic load;      // latch the accepted item
    logic sweep;     // clear one visited entry and set its walls
    logic seed;      // mark and push the start cell
    logic pop;       // read the stack top, drop the level
    logic take_cur;  // capture the popped cell
    logic probe_rd;  // read the visited bit of the current neighbor
    logic next_k;    // move to the next shuffled direction
    logic carve1;
    logic carve2;
    logic carve3;
    logic emit;      // load the output register
  } gmb_cmd_t;

  typedef struct packed {
    logic is_step;
    logic start_ok;
    logic stack_empty;
    logic sweep_last;
    logic probe_ok;
    logic probe_last;
    logic vis_hit;
    logic out_free;
  } gmb_sts_t;

endpackage

`default_nettype wire

// File: rtl/gmb_ctrl.sv
// Controller state machine of the maze backtracker.
`default_nettype none

module gmb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gmb_pkg::gmb_sts_t sts,
  output gmb_pkg::gmb_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_SEED,
    S_POP,
    S_LOAD_CUR,
    S_PROBE,
    S_CHECK,
    S_CARVE1,
    S_CARVE2,
    S_CARVE3,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (!sts.is_step) begin
            state_nxt = sts.start_ok ? S_SWEEP : S_EMIT;
          end else begin
            state_nxt = sts.stack_empty ? S_EMIT : S_POP;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_LOAD_CUR;
      end
      S_LOAD_CUR: begin
        cmd.take_cur = 1'b1;
        state_nxt    = S_PROBE;
      end
      S_PROBE: begin
        // Out-of-grid directions are skipped without a memory read.
        if (sts.probe_ok) begin
          cmd.probe_rd = 1'b1;
          state_nxt    = S_CHECK;
        end else if (sts.probe_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.next_k = 1'b1;
        end
      end
      S_CHECK: begin
        if (!sts.vis_hit) begin
          state_nxt = S_CARVE1;
        end else if (sts.probe_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.next_k = 1'b1;
          state_nxt  = S_PROBE;
        end
      end
      S_CARVE1: begin
        cmd.carve1 = 1'b1;
        state_nxt  = S_CARVE2;
      end
      S_CARVE2: begin
        cmd.carve2 = 1'b1;
        state_nxt  = S_CARVE3;
      end
      S_CARVE3: begin
        cmd.carve3 = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gmb_dpath.sv
// Datapath of the maze backtracker: registers, visited/wall/stack memories and neighbor logic.
`default_nettype none

module gmb_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [gmb_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_action,
  input  logic [gmb_pkg::ROW_W-1:0]         in_start_row,
  input  logic [gmb_pkg::COL_W-1:0]         in_start_col,
  input  logic [7:0]                        in_swap_picks,
  input  gmb_pkg::gmb_cmd_t                 cmd,
  output gmb_pkg::gmb_sts_t                 sts,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic                              out_carved,
  output logic [gmb_pkg::ROW_W-1:0]         out_cell_row,
  output logic [gmb_pkg::COL_W-1:0]         out_cell_col,
  output logic [gmb_pkg::DIR_W-1:0]         out_direction,
  output logic                              out_finished,
  output logic                              out_start_rejected
);

  localparam logic [gmb_pkg::CFG_W-1:0] MaxRowsC = gmb_pkg::CFG_W'(gmb_pkg::MAX_ROWS);
  localparam logic [gmb_pkg::CFG_W-1:0] MaxColsC = gmb_pkg::CFG_W'(gmb_pkg::MAX_COLS);

  typedef logic [3:0][gmb_pkg::DIR_W-1:0] order_t;

  function automatic logic [gmb_pkg::CELL_W-1:0] cell_idx(
    input logic [gmb_pkg::ROW_W-1:0] r,
    input logic [gmb_pkg::COL_W-1:0] c
  );
    return gmb_pkg::CELL_W'(r) * gmb_pkg::CELL_W'(gmb_pkg::MAX_COLS) + gmb_pkg::CELL_W'(c);
  endfunction

  // Four dependent swaps starting from top, right, bottom, left.
  function automatic order_t shuffle(input logic [7:0] picks);
    order_t                     o;
    logic [gmb_pkg::DIR_W-1:0]  j;
    logic [gmb_pkg::DIR_W-1:0]  t;
    o[0] = gmb_pkg::DIR_TOP;
    o[1] = gmb_pkg::DIR_RIGHT;
    o[2] = gmb_pkg::DIR_BOTTOM;
    o[3] = gmb_pkg::DIR_LEFT;
    for (int i = 0; i < 4; i++) begin
      j    = picks[2*i +: 2];
      t    = o[i];
      o[i] = o[j];
      o[j] = t;
    end
    return o;
  endfunction

  // Control and configuration registers.
  logic [gmb_pkg::CFG_W-1:0]  rows_r, cols_r;
  logic [gmb_pkg::LVL_W-1:0]  level_r;
  logic                       out_tvalid_r;

  // Item and walk registers.
  logic                       action_r;
  logic                       reject_r;
  logic [gmb_pkg::ROW_W-1:0]  srow_r;
  logic [gmb_pkg::COL_W-1:0]  scol_r;
  order_t                     order_r;
  logic [gmb_pkg::CELL_W-1:0] cur_r;
  logic [gmb_pkg::CELL_W-1:0] nbr_r;
  logic [1:0]                 k_r;
  logic [gmb_pkg::DIR_W-1:0]  dcand_r;
  logic [gmb_pkg::DIR_W-1:0]  dir_r;
  logic                       carved_r;
  logic [gmb_pkg::CELL_W-1:0] sweep_r;

  // Output register.
  logic                       out_carved_r;
  logic [gmb_pkg::ROW_W-1:0]  out_row_r;
  logic [gmb_pkg::COL_W-1:0]  out_col_r;
  logic [gmb_pkg::DIR_W-1:0]  out_dir_r;
  logic                       out_fin_r;
  logic                       out_rej_r;

  // Memories and their registered read data.
  logic                         vis_mem  [gmb_pkg::NUM_CELLS];
  logic [gmb_pkg::WALL_W-1:0]   wall_mem [gmb_pkg::NUM_CELLS];
  logic [gmb_pkg::CELL_W-1:0]   stk_mem  [gmb_pkg::NUM_CELLS];
  logic                         vis_rd_r;
  logic [gmb_pkg::WALL_W-1:0]   wall_rd_r;
  logic [gmb_pkg::CELL_W-1:0]   stk_rd_r;

  logic [gmb_pkg::CFG_W-1:0]  nr_eff, nc_eff;
  logic                       start_ok;
  logic [gmb_pkg::ROW_W-1:0]  cur_row, nrow;
  logic [gmb_pkg::COL_W-1:0]  cur_col, ncol;
  logic [gmb_pkg::DIR_W-1:0]  pdir;
  logic                       pok;
  logic [gmb_pkg::CELL_W-1:0] nbr_idx;
  logic [gmb_pkg::CELL_W-1:0] s_idx;
  logic [gmb_pkg::LVL_W-1:0]  lvl_dec, lvl_inc;

  logic                         vis_we, vis_wd;
  logic [gmb_pkg::CELL_W-1:0]   vis_wa;
  logic                         wall_we, wall_re;
  logic [gmb_pkg::CELL_W-1:0]   wall_wa, wall_ra;
  logic [gmb_pkg::WALL_W-1:0]   wall_wd;
  logic                         stk_we;
  logic [gmb_pkg::CELL_W-1:0]   stk_wa, stk_wd;

  assign nr_eff = (rows_r > MaxRowsC) ? MaxRowsC : rows_r;
  assign nc_eff = (cols_r > MaxColsC) ? MaxColsC : cols_r;

  assign start_ok = (in_start_row != '0) && (in_start_col != '0) &&
                    (gmb_pkg::CFG_W'(in_start_row) < nr_eff) &&
                    (gmb_pkg::CFG_W'(in_start_col) < nc_eff);

  assign cur_row = gmb_pkg::ROW_W'(cur_r / gmb_pkg::MAX_COLS);
  assign cur_col = gmb_pkg::COL_W'(cur_r % gmb_pkg::MAX_COLS);
  assign pdir    = order_r[k_r];

  always_comb begin
    pok  = 1'b0;
    nrow = cur_row;
    ncol = cur_col;
    case (pdir)
      gmb_pkg::DIR_TOP: begin
        pok  = (cur_row != '0);
        nrow = cur_row - gmb_pkg::ROW_W'(1);
      end
      gmb_pkg::DIR_RIGHT: begin
        pok  = (gmb_pkg::CFG_W'(cur_col) + gmb_pkg::CFG_W'(1)) < nc_eff;
        ncol = cur_col + gmb_pkg::COL_W'(1);
      end
      gmb_pkg::DIR_BOTTOM: begin
        pok  = (gmb_pkg::CFG_W'(cur_row) + gmb_pkg::CFG_W'(1)) < nr_eff;
        nrow = cur_row + gmb_pkg::ROW_W'(1);
      end
      gmb_pkg::DIR_LEFT: begin
        pok  = (cur_col != '0);
        ncol = cur_col - gmb_pkg::COL_W'(1);
      end
      default: begin
        pok = 1'b0;
      end
    endcase
  end

  assign nbr_idx = cell_idx(nrow, ncol);
  assign s_idx   = cell_idx(srow_r, scol_r);
  assign lvl_dec = level_r - gmb_pkg::LVL_W'(1);
  assign lvl_inc = level_r + gmb_pkg::LVL_W'(1);

  assign sts.is_step     = (in_action == gmb_pkg::ACT_STEP);
  assign sts.start_ok    = start_ok;
  assign sts.stack_empty = (level_r == '0);
  assign sts.sweep_last  = (sweep_r == gmb_pkg::CELL_W'(gmb_pkg::NUM_CELLS - 1));
  assign sts.probe_ok    = pok;
  assign sts.probe_last  = (k_r == 2'd3);
  assign sts.vis_hit     = vis_rd_r;
  assign sts.out_free    = !out_tvalid_r || out_tready;

  // Write and read port selection for the three memories.
  always_comb begin
    vis_we  = 1'b0;
    vis_wa  = sweep_r;
    vis_wd  = 1'b0;
    wall_we = 1'b0;
    wall_wa = sweep_r;
    wall_wd = '1;
    wall_re = cmd.carve1 || cmd.carve2;
    wall_ra = cmd.carve2 ? nbr_r : cur_r;
    stk_we  = 1'b0;
    stk_wa  = '0;
    stk_wd  = s_idx;
    if (cmd.sweep) begin
      vis_we  = 1'b1;
      wall_we = 1'b1;
    end
    if (cmd.seed) begin
      vis_we = 1'b1;
      vis_wa = s_idx;
      vis_wd = 1'b1;
      stk_we = 1'b1;
    end
    if (cmd.carve1) begin
      vis_we = 1'b1;
      vis_wa = nbr_r;
      vis_wd = 1'b1;
      // A push beyond the stack depth is dropped.
      stk_we = (level_r < gmb_pkg::LVL_W'(gmb_pkg::NUM_CELLS));
      stk_wa = level_r[gmb_pkg::CELL_W-1:0];
      stk_wd = cur_r;
    end
    if (cmd.carve2) begin
      wall_we = 1'b1;
      wall_wa = cur_r;
      wall_wd = wall_rd_r & ~(gmb_pkg::WALL_W'(1) << dir_r);
      stk_we  = (lvl_inc < gmb_pkg::LVL_W'(gmb_pkg::NUM_CELLS));
      stk_wa  = lvl_inc[gmb_pkg::CELL_W-1:0];
      stk_wd  = nbr_r;
    end
    if (cmd.carve3) begin
      wall_we = 1'b1;
      wall_wa = nbr_r;
      wall_wd = wall_rd_r & ~(gmb_pkg::WALL_W'(1) << (dir_r + gmb_pkg::DIR_W'(2)));
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (cmd.probe_rd) begin
      vis_rd_r <= vis_mem[nbr_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_wa] <= wall_wd;
    end
    if (wall_re) begin
      wall_rd_r <= wall_mem[wall_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd.pop) begin
      stk_rd_r <= stk_mem[lvl_dec[gmb_pkg::CELL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r       <= gmb_pkg::CFG_RESET;
      cols_r       <= gmb_pkg::CFG_RESET;
      level_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gmb_pkg::REG_ROWS) begin
          rows_r <= cfg_wdata;
        end else begin
          cols_r <= cfg_wdata;
        end
      end
      if (cmd.seed) begin
        level_r <= gmb_pkg::LVL_W'(1);
      end else if (cmd.pop) begin
        level_r <= lvl_dec;
      end else if (cmd.carve3) begin
        level_r <= level_r + gmb_pkg::LVL_W'(2);
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      reject_r <= (in_action == gmb_pkg::ACT_START) && !start_ok;
      srow_r   <= in_start_row;
      scol_r   <= in_start_col;
      order_r  <= shuffle(in_swap_picks);
      cur_r    <= '0;
      carved_r <= 1'b0;
      dir_r    <= gmb_pkg::DIR_TOP;
      sweep_r  <= '0;
      k_r      <= '0;
    end
    if (cmd.sweep) begin
      sweep_r <= sweep_r + gmb_pkg::CELL_W'(1);
    end
    if (cmd.take_cur) begin
      cur_r <= stk_rd_r;
      k_r   <= '0;
    end
    if (cmd.probe_rd) begin
      nbr_r   <= nbr_idx;
      dcand_r <= pdir;
    end
    if (cmd.next_k) begin
      k_r <= k_r + 2'd1;
    end
    if (cmd.carve1) begin
      carved_r <= 1'b1;
      dir_r    <= dcand_r;
    end
    if (cmd.emit) begin
      out_carved_r <= carved_r;
      out_row_r    <= (action_r == gmb_pkg::ACT_STEP) ? cur_row : srow_r;
      out_col_r    <= (action_r == gmb_pkg::ACT_STEP) ? cur_col : scol_r;
      out_dir_r    <= dir_r;
      out_fin_r    <= (level_r == '0);
      out_rej_r    <= reject_r;
    end
  end

  assign out_tvalid         = out_tvalid_r;
  assign out_carved         = out_carved_r;
  assign out_cell_row       = out_row_r;
  assign out_cell_col       = out_col_r;
  assign out_direction      = out_dir_r;
  assign out_finished       = out_fin_r;
  assign out_start_rejected = out_rej_r;

endmodule

`default_nettype wire

// File: rtl/grid_maze_backtracker.sv
// Top level of the grid maze backtracker: stream ports, controller and datapath.
//
//  channel  | direction | handshake          | payload
//  in_      | slave     | tvalid/tready      | tuser action, tdata start cell and swap picks
//  out_     | master    | tvalid/tready      | tdata cell and direction, tuser flags, tlast
//  cfg_     | write     | cfg_we             | cfg_index register, cfg_wdata value
//
// One item is handled at a time. A step goes from acceptance to result through a stack read
// of the popped cell, then a visited-memory read and check for each neighbor probed, and
// visited, wall and stack writes in the carve states when a passage is carved.
// An accepted start runs the one-entry-per-cycle sweep that clears the visited memory and
// sets every wall; a rejected start or a step on an empty stack goes straight to the result.
// Reset empties the stack; a full output register holds its result and stalls the next emit.
`default_nettype none

module grid_maze_backtracker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gmb_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // start_row, start_col, swap_picks, unused
  input  logic                      in_tuser,   // action
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // cell_row, cell_col, direction, zero fill
  output logic [1:0]                out_tuser,  // carved, start_rejected
  output logic                      out_tlast   // finished
);

  gmb_pkg::gmb_cmd_t cmd;
  gmb_pkg::gmb_sts_t sts;

  logic                        out_carved, out_finished, out_start_rejected;
  logic [gmb_pkg::ROW_W-1:0]   out_cell_row;
  logic [gmb_pkg::COL_W-1:0]   out_cell_col;
  logic [gmb_pkg::DIR_W-1:0]   out_direction;

  gmb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gmb_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_tuser),
    .in_start_row       (in_tdata[4:0]),
    .in_start_col       (in_tdata[9:5]),
    .in_swap_picks      (in_tdata[17:10]),
    .cmd                (cmd),
    .sts                (sts),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_carved         (out_carved),
    .out_cell_row       (out_cell_row),
    .out_cell_col       (out_cell_col),
    .out_direction      (out_direction),
    .out_finished       (out_finished),
    .out_start_rejected (out_start_rejected)
  );

  assign out_tdata = {4'b0000, out_direction, out_cell_col, out_cell_row};
  assign out_tuser = {out_start_rejected, out_carved};
  assign out_tlast = out_finished;

`include "assert_macros.svh"

  // The output register is only loaded when it is empty or being drained.
  `GMB_ASSERT_IMPLY(a_emit_free, clk, rst_n, cmd.emit, sts.out_free, "result loaded over a pending result")

  // Items are taken one at a time.
  `GMB_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "item accepted while busy")

  // A carve always leaves at least two cells on the stack.
  `GMB_ASSERT_IMPLY(a_carve_not_fin, clk, rst_n, out_tvalid && out_tuser[0], !out_tlast && !out_tuser[1], "carve reported with finished or rejected")

endmodule

`default_nettype wire
